@@ hdl/gdd_pkg.sv @@
package gdd_pkg;

	// Field widths of one beat.
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned DIFF_W  = 22;

	// Internal widths.
	localparam int unsigned QUOT_W  = 8;   // year / 100 for any 14-bit year
	localparam int unsigned PROD_W  = 27;  // 14-bit year times the reciprocal
	localparam int unsigned LEAPS_W = 11;  // leap days since the base year
	localparam int unsigned PART_W  = 9;   // month start plus day plus leap day

	// Calendar constants.
	localparam logic [YEAR_W-1:0]  BASE_YEAR         = 14'd1601;
	localparam logic [YEAR_W-1:0]  LAST_YEAR         = 14'd9999;
	localparam logic [YEAR_W-1:0]  LEAPS_BEFORE_BASE = 14'd388;
	localparam logic [MONTH_W-1:0] JANUARY           = 4'd1;
	localparam logic [MONTH_W-1:0] FEBRUARY          = 4'd2;
	localparam logic [MONTH_W-1:0] DECEMBER          = 4'd12;

	// Division by 100 as multiply and shift: exact for all 14-bit values.
	localparam logic [PROD_W-1:0] RECIP_100  = 27'd5243;
	localparam int unsigned       RECIP_SHIFT = 19;

	typedef struct packed {
		logic [DAY_W-1:0]   first_day;
		logic [MONTH_W-1:0] first_month;
		logic [YEAR_W-1:0]  first_year;
		logic [DAY_W-1:0]   second_day;
		logic [MONTH_W-1:0] second_month;
		logic [YEAR_W-1:0]  second_year;
	} dates_t;

	typedef struct packed {
		logic [DIFF_W-1:0] day_difference;
		logic              out_of_range;
	} diff_t;

	// Days of the months before the given month in a common year.
	function automatic logic [PART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
		logic [PART_W-1:0] r;
		case (m)
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/gregorian_date_difference_top.sv @@
// Pipeline: stages s1, s2, s3 and s4 lie between an accepted beat on dates and
// its beat on diff. Throughput: one date pair per cycle while diff_stall is low;
// each stage holds one item and moves on whenever the stage after it is empty or
// moving, so bubbles close up under stall. Reset: arst_n clears all stage valid
// bits asynchronously; data registers are not reset.
module gregorian_date_difference_top
	import gdd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   dates_valid,
	output logic   dates_stall,
	input  dates_t dates,
	output logic   diff_valid,
	input  logic   diff_stall,
	output diff_t  diff
);

	// Per-date lanes of the incoming beat.
	logic [DAY_W-1:0]   day_in  [2];
	logic [MONTH_W-1:0] mon_in  [2];
	logic [YEAR_W-1:0]  year_in [2];
	logic [1:0]         bad_in;
	logic [PROD_W-1:0]  prod_p  [2];
	logic [PROD_W-1:0]  prod_y  [2];

	// Stage registers.
	logic                v_s1, v_s2, v_s3, v_s4;
	logic                bad_s1, bad_s2, bad_s3;
	logic [DAY_W-1:0]    day_s1  [2];
	logic [MONTH_W-1:0]  mon_s1  [2];
	logic [YEAR_W-1:0]   year_s1 [2];
	logic [QUOT_W-1:0]   qp_s1   [2];
	logic [QUOT_W-1:0]   qy_s1   [2];
	logic [YEAR_W-1:0]   yoff_s2 [2];
	logic [LEAPS_W-1:0]  leaps_s2[2];
	logic [PART_W-1:0]   part_s2 [2];
	logic [DIFF_W-1:0]   num_s3  [2];
	diff_t               res_s4;

	// Stage 2, 3 and 4 combinational results.
	logic [YEAR_W-1:0]   p_c     [2];
	logic [YEAR_W-1:0]   ry_c    [2];
	logic                leap_c  [2];
	logic [YEAR_W-1:0]   leaps_c [2];
	logic [PART_W-1:0]   part_c  [2];
	logic [DIFF_W-1:0]   num_c   [2];
	logic [DIFF_W-1:0]   diff_c;

	// Stage advance: a stage loads when it is empty or its content moves on.
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4 = !v_s4 || !diff_stall;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign dates_stall = !rdy1;

	// Stage 1 logic: range checks and, per date, the two divisions by 100.
	always_comb begin
		day_in[0]  = dates.first_day;
		mon_in[0]  = dates.first_month;
		year_in[0] = dates.first_year;
		day_in[1]  = dates.second_day;
		mon_in[1]  = dates.second_month;
		year_in[1] = dates.second_year;
		for (int i = 0; i < 2; i++) begin
			bad_in[i] = (year_in[i] < BASE_YEAR) || (year_in[i] > LAST_YEAR) ||
				(mon_in[i] < JANUARY) || (mon_in[i] > DECEMBER) || (day_in[i] == '0);
			prod_p[i] = PROD_W'(year_in[i] - 14'd1) * RECIP_100;
			prod_y[i] = PROD_W'(year_in[i]) * RECIP_100;
		end
	end

	// Stage 2 logic: leap days before the year, leap flag and day in year.
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			p_c[i]     = year_s1[i] - 14'd1;
			ry_c[i]    = year_s1[i] - YEAR_W'(qy_s1[i]) * 14'd100;
			leap_c[i]  = (year_s1[i][1:0] == 2'b00) &&
				((ry_c[i] != '0) || (qy_s1[i][1:0] == 2'b00));
			leaps_c[i] = (p_c[i] >> 2) - YEAR_W'(qp_s1[i]) + YEAR_W'(qp_s1[i] >> 2)
				- LEAPS_BEFORE_BASE;
			part_c[i]  = month_start(mon_s1[i]) + PART_W'(day_s1[i]) +
				PART_W'(leap_c[i] && (mon_s1[i] > FEBRUARY));
		end
	end

	// Stage 3 logic: day number counted from the base year.
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			num_c[i] = DIFF_W'(yoff_s2[i]) * 22'd365 + DIFF_W'(leaps_s2[i]) +
				DIFF_W'(part_s2[i]);
		end
	end

	// Stage 4 logic: absolute difference.
	assign diff_c = (num_s3[0] >= num_s3[1]) ? (num_s3[0] - num_s3[1]) :
		(num_s3[1] - num_s3[0]);

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= dates_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Data registers.
	always_ff @(posedge clk) begin
		if (rdy1 && dates_valid) begin
			bad_s1 <= |bad_in;
			for (int i = 0; i < 2; i++) begin
				day_s1[i]  <= day_in[i];
				mon_s1[i]  <= mon_in[i];
				year_s1[i] <= year_in[i];
				qp_s1[i]   <= prod_p[i][RECIP_SHIFT +: QUOT_W];
				qy_s1[i]   <= prod_y[i][RECIP_SHIFT +: QUOT_W];
			end
		end
		if (rdy2 && v_s1) begin
			bad_s2 <= bad_s1;
			for (int i = 0; i < 2; i++) begin
				yoff_s2[i]  <= year_s1[i] - BASE_YEAR;
				leaps_s2[i] <= leaps_c[i][LEAPS_W-1:0];
				part_s2[i]  <= part_c[i];
			end
		end
		if (rdy3 && v_s2) begin
			bad_s3 <= bad_s2;
			for (int i = 0; i < 2; i++) begin
				num_s3[i] <= num_c[i];
			end
		end
		if (rdy4 && v_s3) begin
			res_s4.out_of_range   <= bad_s3;
			res_s4.day_difference <= bad_s3 ? '0 : diff_c;
		end
	end

	assign diff_valid = v_s4;
	assign diff       = res_s4;

endmodule

@@ hdl/gdd_checker.sv @@
module gdd_checker
	import gdd_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   dates_valid,
	input logic   dates_stall,
	input dates_t dates,
	input logic   diff_valid,
	input logic   diff_stall,
	input diff_t  diff
);

	// A stalled result beat stays put.
	a_diff_hold: assert property (@(posedge clk) disable iff (!arst_n)
		diff_valid && diff_stall |=> diff_valid && $stable(diff))
		else $error("diff beat changed under stall");

	// The input side backs up only when the whole pipeline is full.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		dates_stall |-> diff_valid && diff_stall)
		else $error("dates stalled while the output was free");

	// A flagged result carries a zero difference.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		diff_valid && diff.out_of_range |-> diff.day_difference == '0)
		else $error("out_of_range result with nonzero difference");

	// Every difference stays at or below 3100000 days, above the span of the calendar range.
	a_diff_bound: assert property (@(posedge clk) disable iff (!arst_n)
		diff_valid |-> diff.day_difference <= 22'd3100000)
		else $error("day difference beyond calendar span");

endmodule

bind gregorian_date_difference_top gdd_checker u_gdd_checker (.*);
